// File: src/serial_tx_framer_parity_unit_macros.svh
// Assertion macros for the serial transmit framer with parity.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef SERIAL_TX_FRAMER_PARITY_UNIT_MACROS_SVH
`define SERIAL_TX_FRAMER_PARITY_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside of reset.
`define STFP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("stfp assertion failed");
// Checked on every rising clock edge, reset included.
`define STFP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("stfp assertion failed");
`else
`define STFP_ASSERT(label, clk, rst_n, prop)
`define STFP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: src/stfp_pkg.sv
// Shared types and constants of the serial transmit framer with parity.
// No dependencies; imported by every module of the block.
`default_nettype none

package stfp_pkg;

  localparam int unsigned TickW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] BitTicksRst  = 16'd100;
  localparam logic [TickW-1:0] LeadTicksRst = 16'd100;
  localparam logic [TickW-1:0] StopTicksRst = 16'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BIT_TICKS  = 2'd0,
    CFG_LEAD_TICKS = 2'd1,
    CFG_STOP_TICKS = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LEAD   = 3'd1,
    PH_START  = 3'd2,
    PH_DATA   = 3'd3,
    PH_PARITY = 3'd4,
    PH_STOP   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [TickW-1:0] bit_ticks;
    logic [TickW-1:0] lead_ticks;
    logic [TickW-1:0] stop_ticks;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic rejected;
  } result_t;

endpackage

`default_nettype wire

// File: src/stfp_cfg.sv
// Configuration register file of the serial transmit framer: period lengths in ticks.
// Depends on stfp_pkg.
`default_nettype none

module stfp_cfg
  import stfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TickW-1:0]   cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BIT_TICKS:  cfg_d.bit_ticks  = cfg_data_i;
        CFG_LEAD_TICKS: cfg_d.lead_ticks = cfg_data_i;
        CFG_STOP_TICKS: cfg_d.stop_ticks = cfg_data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_ticks  <= BitTicksRst;
      cfg_q.lead_ticks <= LeadTicksRst;
      cfg_q.stop_ticks <= StopTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/stfp_core.sv
// Frame sequencer of the serial transmit framer: phase, shifter, parity and tick counter.
// Depends on stfp_pkg and the assertion macros header.
`default_nettype none
`include "serial_tx_framer_parity_unit_macros.svh"

module stfp_core
  import stfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             mode_i,
  input  wire logic [ByteW-1:0] tx_byte_i,
  input  wire cfg_t             cfg_i,
  output result_t               res_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] shift_q, shift_d;
  logic [2:0]       bit_idx_q, bit_idx_d;
  logic             parity_q, parity_d;
  logic [TickW-1:0] tick_q, tick_d;

  logic             busy;
  logic             level;
  logic [TickW-1:0] period_len;
  logic [TickW-1:0] tick_inc;

  // Phase codes outside lead..stop behave as idle.
  assign busy = phase_q inside {PH_LEAD, PH_START, PH_DATA, PH_PARITY, PH_STOP};

  always_comb begin
    case (phase_q)
      PH_START:  level = 1'b0;
      PH_DATA:   level = shift_q[ByteW-1];
      PH_PARITY: level = parity_q;
      default:   level = 1'b1;
    endcase
  end

  // A programmed length of zero counts as one tick.
  always_comb begin
    case (phase_q)
      PH_LEAD: period_len = cfg_i.lead_ticks;
      PH_STOP: period_len = cfg_i.stop_ticks;
      default: period_len = cfg_i.bit_ticks;
    endcase
    if (period_len == '0) begin
      period_len = TickW'(1);
    end
  end

  assign tick_inc = tick_q + TickW'(1);

  // Next state.
  always_comb begin
    phase_d   = phase_q;
    shift_d   = shift_q;
    bit_idx_d = bit_idx_q;
    parity_d  = parity_q;
    tick_d    = tick_q;
    if (accept_i) begin
      if (!busy) begin
        phase_d = PH_IDLE;
      end
      if (mode_i) begin
        if (!busy) begin
          shift_d   = tx_byte_i;
          parity_d  = ^tx_byte_i;
          bit_idx_d = '0;
          tick_d    = '0;
          phase_d   = PH_LEAD;
        end
      end else if (busy) begin
        tick_d = tick_inc;
        if (tick_inc >= period_len) begin
          tick_d = '0;
          case (phase_q)
            PH_LEAD: begin
              phase_d = PH_START;
            end
            PH_START: begin
              phase_d   = PH_DATA;
              bit_idx_d = '0;
            end
            PH_DATA: begin
              shift_d = {shift_q[ByteW-2:0], 1'b0};
              if (bit_idx_q == 3'd7) begin
                bit_idx_d = '0;
                phase_d   = PH_PARITY;
              end else begin
                bit_idx_d = bit_idx_q + 3'd1;
              end
            end
            PH_PARITY: begin
              phase_d = PH_STOP;
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  // Result of the transaction being accepted, taken from the state before it.
  always_comb begin
    res_o.line_level = busy ? level : 1'b1;
    res_o.busy_res   = mode_i | busy;
    res_o.rejected   = mode_i & busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      shift_q   <= '0;
      bit_idx_q <= '0;
      parity_q  <= 1'b0;
      tick_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      shift_q   <= shift_d;
      bit_idx_q <= bit_idx_d;
      parity_q  <= parity_d;
      tick_q    <= tick_d;
    end
  end

  `STFP_ASSERT(a_idle_no_ticks, clk_i, rst_ni, (phase_q == PH_IDLE) |-> (tick_q == '0))
  `STFP_ASSERT(a_bit_idx_only_in_data, clk_i, rst_ni, (phase_q != PH_DATA) |-> (bit_idx_q == '0))
  `STFP_ASSERT(a_reject_keeps_phase, clk_i, rst_ni, (accept_i && mode_i && busy) |=> $stable(phase_q))

endmodule

`default_nettype wire

// File: src/serial_tx_framer_parity_unit.sv
// Top level of the tick-driven serial transmit framer with even parity.
// Depends on stfp_pkg, stfp_cfg, stfp_core and the assertion macros header.
//
// Usage: every transaction on the input channel is either a time tick (mode_i = 0)
// or a send request (mode_i = 1) carrying tx_byte_i. A send while idle loads the byte
// and starts a frame: a high lead period, a low start bit, eight data bits sent most
// significant bit first, an even parity bit and a high stop period. Each tick advances
// the frame by one tick and reports the line level in that tick. A send while a frame
// is running is dropped and flagged with rejected_o.
// Every input transaction produces exactly one output transaction carrying
// line_level_o, busy_res_o and rejected_o. The result appears in the cycle after
// acceptance, from the output register, and one transaction can be accepted every
// cycle: the frame state and the result are updated by a single short pass of logic.
// When the receiver stalls, the result waits in the output register and a further
// input transaction is taken only in a cycle in which that register drains.
// Period lengths are set through the write port (index 0 bit ticks, 1 lead ticks,
// 2 stop ticks; index 3 is ignored); a new length takes effect at once, mid-frame too.
// Reset sets the lengths to 100, 100 and 200 ticks, returns the sequencer to idle
// and empties the output register.
`default_nettype none
`include "serial_tx_framer_parity_unit_macros.svh"

module serial_tx_framer_parity_unit
  import stfp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic               mode_i,
  input  wire logic [ByteW-1:0]   tx_byte_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic               line_level_o,
  output      logic               busy_res_o,
  output      logic               rejected_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [TickW-1:0]   cfg_data_i
);

  cfg_t    cfg;
  result_t res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;
  logic    accept;

  // The output register frees up in the same cycle it is taken by the receiver.
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  stfp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  stfp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .mode_i    (mode_i),
    .tx_byte_i (tx_byte_i),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = res_q.line_level;
  assign busy_res_o   = res_q.busy_res;
  assign rejected_o   = res_q.rejected;

  `STFP_ASSERT(a_accept_gives_result, clk_i, rst_ni, accept |=> out_valid_q)
  `STFP_ASSERT(a_reject_implies_busy, clk_i, rst_ni, (out_valid_q && rejected_o) |-> busy_res_o)
  `STFP_ASSERT(a_idle_line_high, clk_i, rst_ni, (out_valid_q && !busy_res_o) |-> line_level_o)

endmodule

`default_nettype wire
